FILE: src/tccw_pkg.sv
package tccw_pkg;

  // grid geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;

  // field widths
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);

  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  // operation codes
  typedef enum logic [2:0] {
    OP_PUT_POS = 3'd0,
    OP_PUT_CUR = 3'd1,
    OP_CLR_ROW = 3'd2,
    OP_CLR_SCR = 3'd3,
    OP_READ    = 3'd4
  } opcode_t;

  // cell store write request
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [15:0]       data;
  } cell_wr_t;

endpackage

FILE: src/tccw_cell_ram.sv
module tccw_cell_ram
  import tccw_pkg::*;
(
  input  logic              clk,
  input  cell_wr_t          wr,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [15:0]       rd_data
);

  logic [15:0] mem [CELLS];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/tccw_addr_unit.sv
module tccw_addr_unit
  import tccw_pkg::*;
(
  input  logic [ROW_W-1:0]  top_row,
  input  logic [ROW_W-1:0]  row,
  input  logic [COL_W-1:0]  col,
  output logic [ADDR_W-1:0] addr
);

  logic [ROW_W:0]   row_sum;
  logic [ROW_W-1:0] phys_row;

  // logical row to physical row in the ring of rows
  assign row_sum  = {1'b0, top_row} + {1'b0, row};
  assign phys_row = (row_sum >= (ROW_W+1)'(ROWS)) ? ROW_W'(row_sum - (ROW_W+1)'(ROWS))
                                                   : row_sum[ROW_W-1:0];

  // row base plus column
  assign addr = ADDR_W'(phys_row) * ADDR_W'(COLUMNS) + ADDR_W'(col);

endmodule

FILE: src/text_console_cell_writer_core.sv
// Text console with a ROWS x COLUMNS grid of 16-bit cells (character in the low byte,
// attribute in the high byte) and a cursor. Each input transaction returns exactly one
// result transaction. The block takes one item at a time under a small sequencer that
// reuses one address unit ((top + row) mod ROWS) * COLUMNS + col and a cell store with one
// write port and one registered read port. Clear row, clear screen and the clearing of
// the new bottom row on a scroll are swept with one write per cycle into the cell store.
// A result still waiting on out_tready holds the next one back. After reset the block
// runs a clearing pass that zeroes every cell, during which in_tready stays low.
// Scrolling moves a top-row index, so only the new bottom row is cleared.
module text_console_cell_writer_core
  import tccw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // opcode[2:0] char_code[10:3] attr[18:11] col[25:19] row[30:26]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // cursor_col[6:0] cursor_row[11:7] read_char[19:12]
                                  // read_attr[27:20] scrolled[28]
);

  typedef enum logic [8:0] {
    S_INIT    = 9'b000000001,
    S_IDLE    = 9'b000000010,
    S_ADDR    = 9'b000000100,
    S_WRITE   = 9'b000001000,
    S_ADVANCE = 9'b000010000,
    S_SCROLL  = 9'b000100000,
    S_SWEEP   = 9'b001000000,
    S_READ    = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_t;

  state_t            state_r;
  logic [2:0]        op_r;
  logic [7:0]        ch_r;
  logic [7:0]        at_r;
  logic [COL_W-1:0]  tgt_col_r;
  logic [ROW_W-1:0]  tgt_row_r;
  logic [COL_W-1:0]  cur_col_r;
  logic [ROW_W-1:0]  cur_row_r;
  logic [ROW_W-1:0]  top_r;
  logic [ADDR_W-1:0] addr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              scrolled_r;
  logic              rd_hit_r;
  logic              out_tvalid_r;
  logic [31:0]       out_tdata_r;

  // input fields
  logic [2:0]       in_op;
  logic [7:0]       in_ch;
  logic [7:0]       in_at;
  logic [COL_W-1:0] in_col;
  logic [ROW_W-1:0] in_row;
  logic             in_inside;

  assign in_op     = in_tdata[2:0];
  assign in_ch     = in_tdata[10:3];
  assign in_at     = in_tdata[18:11];
  assign in_col    = in_tdata[25:19];
  assign in_row    = in_tdata[30:26];
  assign in_inside = ({1'b0, in_col} < (COL_W+1)'(COLUMNS)) &&
                     ({1'b0, in_row} < (ROW_W+1)'(ROWS));

  // shared address unit
  logic [ROW_W-1:0]  au_row;
  logic [COL_W-1:0]  au_col;
  logic [ADDR_W-1:0] au_addr;

  assign au_row = (state_r == S_SCROLL) ? '0 : tgt_row_r;
  assign au_col = ((state_r == S_SCROLL) || (op_r == OP_CLR_ROW)) ? '0 : tgt_col_r;

  tccw_addr_unit u_addr (
    .top_row (top_r),
    .row     (au_row),
    .col     (au_col),
    .addr    (au_addr)
  );

  // cell store
  cell_wr_t    cell_wr;
  logic [15:0] rd_data;

  assign cell_wr.en   = (state_r == S_WRITE) || (state_r == S_SWEEP) || (state_r == S_INIT);
  assign cell_wr.addr = addr_r;
  assign cell_wr.data = (state_r == S_WRITE) ? {at_r, ch_r} : 16'd0;

  tccw_cell_ram u_ram (
    .clk     (clk),
    .wr      (cell_wr),
    .rd_en   (state_r == S_READ),
    .rd_addr (addr_r),
    .rd_data (rd_data)
  );

  // cursor advance after a put
  logic [COL_W:0]   col_inc;
  logic [ROW_W:0]   row_inc;
  logic             adv_wrap;
  logic [COL_W-1:0] adv_col;
  logic [ROW_W:0]   adv_row;
  logic             adv_scroll;

  assign col_inc    = {1'b0, tgt_col_r} + (COL_W+1)'(1);
  assign row_inc    = {1'b0, tgt_row_r} + (ROW_W+1)'(1);
  assign adv_wrap   = (ch_r == NEWLINE_CODE) || (col_inc >= (COL_W+1)'(COLUMNS));
  assign adv_col    = adv_wrap ? '0 : col_inc[COL_W-1:0];
  assign adv_row    = adv_wrap ? row_inc : {1'b0, tgt_row_r};
  assign adv_scroll = (adv_row >= (ROW_W+1)'(ROWS));

  logic             out_free;
  logic [15:0]      rd_sel;

  assign out_free = !out_tvalid_r || out_tready;
  assign rd_sel   = rd_hit_r ? rd_data : 16'd0;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      addr_r       <= '0;
      cnt_r        <= CNT_W'(CELLS);
      top_r        <= '0;
      cur_col_r    <= '0;
      cur_row_r    <= '0;
      scrolled_r   <= 1'b0;
      rd_hit_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      // the done state reloads the result itself
      if (out_tvalid_r && out_tready && (state_r != S_DONE)) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_INIT: begin
          addr_r <= addr_r + ADDR_W'(1);
          cnt_r  <= cnt_r - CNT_W'(1);
          if (cnt_r == CNT_W'(1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_tvalid) begin
            op_r       <= in_op;
            ch_r       <= in_ch;
            at_r       <= in_at;
            tgt_col_r  <= (in_op == OP_PUT_CUR) ? cur_col_r : in_col;
            tgt_row_r  <= (in_op == OP_PUT_CUR) ? cur_row_r : in_row;
            scrolled_r <= 1'b0;
            rd_hit_r   <= 1'b0;
            case (in_op)
              OP_PUT_POS, OP_READ: begin
                state_r <= in_inside ? S_ADDR : S_DONE;
              end
              OP_PUT_CUR: begin
                state_r <= S_ADDR;
              end
              OP_CLR_ROW: begin
                state_r <= ({1'b0, in_row} < (ROW_W+1)'(ROWS)) ? S_ADDR : S_DONE;
              end
              OP_CLR_SCR: begin
                addr_r    <= '0;
                cnt_r     <= CNT_W'(CELLS);
                top_r     <= '0;
                cur_col_r <= '0;
                cur_row_r <= '0;
                state_r   <= S_SWEEP;
              end
              default: begin
                state_r <= S_DONE;
              end
            endcase
          end
        end
        S_ADDR: begin
          addr_r <= au_addr;
          case (op_r)
            OP_PUT_POS, OP_PUT_CUR: begin
              state_r <= (ch_r == NEWLINE_CODE) ? S_ADVANCE : S_WRITE;
            end
            OP_CLR_ROW: begin
              cnt_r   <= CNT_W'(COLUMNS);
              state_r <= S_SWEEP;
            end
            default: begin
              state_r <= S_READ;
            end
          endcase
        end
        S_WRITE: begin
          state_r <= S_ADVANCE;
        end
        S_ADVANCE: begin
          cur_col_r <= adv_col;
          if (adv_scroll) begin
            scrolled_r <= 1'b1;
            cur_row_r  <= ROW_W'(ROWS - 1);
            state_r    <= S_SCROLL;
          end else begin
            cur_row_r <= adv_row[ROW_W-1:0];
            state_r   <= S_DONE;
          end
        end
        S_SCROLL: begin
          // clear the old top row, which becomes the new bottom row
          addr_r  <= au_addr;
          cnt_r   <= CNT_W'(COLUMNS);
          top_r   <= (top_r == ROW_W'(ROWS - 1)) ? '0 : top_r + ROW_W'(1);
          state_r <= S_SWEEP;
        end
        S_SWEEP: begin
          addr_r <= addr_r + ADDR_W'(1);
          cnt_r  <= cnt_r - CNT_W'(1);
          if (cnt_r == CNT_W'(1)) begin
            state_r <= S_DONE;
          end
        end
        S_READ: begin
          rd_hit_r <= 1'b1;
          state_r  <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_tdata_r  <= {3'd0, scrolled_r, rd_sel[15:8], rd_sel[7:0], cur_row_r, cur_col_r};
            out_tvalid_r <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

FILE: src/tccw_checker.sv
module tccw_checker
  import tccw_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // a stalled result transaction stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  // a stalled result transaction keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result payload changed while stalled");

  // the block works on one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in progress");

  // reset drops the result and starts the clearing pass
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("activity right after reset");

  // a scroll always leaves the cursor on the bottom row
  a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[28] |-> out_tdata[11:7] == ROW_W'(ROWS - 1))
    else $error("scroll reported with cursor off the bottom row");

endmodule

bind text_console_cell_writer_core tccw_checker u_tccw_checker (.*);
